@@ rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg : shared types for the positional list engine
// Transfer structs, action and status codes, and cell-array operations.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Default number of list cells
  localparam int unsigned CapacityDef = 16;

  // Requested operation, as carried in the action field
  typedef enum logic [2:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_INS_POS  = 3'd2,
    ACT_DEL_HEAD = 3'd3,
    ACT_DEL_TAIL = 3'd4,
    ACT_DEL_POS  = 3'd5,
    ACT_READ     = 3'd6
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Operation applied to the cell array
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } store_op_e;

  // Input transfer
  typedef struct packed {
    logic [2:0]         action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } req_t;

  // Result transfer
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic [4:0]         entry_count;
  } rsp_t;

endpackage

@@ rtl/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine : bounded ordered list with positional operations
// Holds up to CAPACITY signed 32-bit entries, head at position 1. An item
// is taken whenever start is high; busy stays low, so one item may be
// given in every cycle. Each item returns exactly one result, on rsp_o
// with done_o high for a single cycle; results come back in order at one
// per cycle. The receiver cannot stall, so done_o must be caught on the
// cycle it appears. Each item passes through the input register and the
// result register around the cell array, which shifts all later entries
// at once for a positional insert or delete. A refused request (full,
// empty or bad position) changes nothing; entry_count is the count held
// after the item, modulo 32.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CapacityDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ple_pkg::req_t req_i,
  output logic          done_o,
  output ple_pkg::rsp_t rsp_o
);
  import ple_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > 5) ? CW : 5) + 1;

  req_t               req_q;
  logic               req_vld_q;
  logic [CW-1:0]      occ_q, occ_d;
  rsp_t               rsp_q, rsp_d;
  logic               done_q;

  store_op_e          op;
  logic [CW-1:0]      idx;
  logic signed [31:0] rd_data;
  logic [CMPW-1:0]    occ_ext, pos_ext;
  logic               full, empty;

  // Every cycle can take an item
  assign busy = 1'b0;

  // Capture the incoming transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  assign occ_ext = CMPW'(occ_q);
  assign pos_ext = CMPW'(req_q.position);
  assign full    = (occ_q == CW'(CAPACITY));
  assign empty   = (occ_q == '0);

  // Decode the held item: checks, cell operation and result
  always_comb begin
    op                = OP_HOLD;
    idx               = '0;
    occ_d             = occ_q;
    rsp_d.status      = ST_OK;
    rsp_d.entry_value = '0;
    if (req_vld_q) begin
      unique case (action_e'(req_q.action))
        ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
          if (full) begin
            rsp_d.status = ST_FULL;
          end else if (action_e'(req_q.action) == ACT_INS_HEAD) begin
            op    = OP_INSERT;
            occ_d = occ_q + 1'b1;
          end else if (action_e'(req_q.action) == ACT_INS_TAIL) begin
            op    = OP_INSERT;
            idx   = occ_q;
            occ_d = occ_q + 1'b1;
          end else if (pos_ext == '0 || pos_ext > occ_ext + 1'b1) begin
            rsp_d.status = ST_BADPOS;
          end else begin
            op    = OP_INSERT;
            idx   = CW'(pos_ext - 1'b1);
            occ_d = occ_q + 1'b1;
          end
        end
        ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_POS, ACT_READ: begin
          if (empty) begin
            rsp_d.status = ST_EMPTY;
          end else if (action_e'(req_q.action) == ACT_DEL_HEAD) begin
            op                = OP_REMOVE;
            occ_d             = occ_q - 1'b1;
            rsp_d.entry_value = rd_data;
          end else if (action_e'(req_q.action) == ACT_DEL_TAIL) begin
            op                = OP_REMOVE;
            idx               = occ_q - 1'b1;
            occ_d             = occ_q - 1'b1;
            rsp_d.entry_value = rd_data;
          end else if (pos_ext == '0 || pos_ext > occ_ext) begin
            rsp_d.status = ST_BADPOS;
          end else begin
            idx               = CW'(pos_ext - 1'b1);
            rsp_d.entry_value = rd_data;
            if (action_e'(req_q.action) == ACT_DEL_POS) begin
              op    = OP_REMOVE;
              occ_d = occ_q - 1'b1;
            end
          end
        end
        default: begin
          rsp_d.status = ST_OK;
        end
      endcase
    end
    rsp_d.entry_count = 5'(occ_d);
  end

  ple_store #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_store (
    .clk_i     (clk_i),
    .op_i      (op),
    .idx_i     (idx),
    .value_i   (req_q.value),
    .rd_data_o (rd_data)
  );

  // Advance the count and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      done_q <= req_vld_q;
    end
  end

  // Register the result; it holds until the next item's result
  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result missing two cycles after transfer");

  a_occ_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_vld_q |=> $stable(occ_q))
    else $error("occupancy changed without an item");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> rsp_o.entry_count == 5'(CAPACITY))
    else $error("full status with list not full");
`endif

endmodule

@@ rtl/ple_store.sv @@
// ----------------------------------------------------------------------------
// ple_store : shifting cell array of the positional list engine
// Each cell takes its own value, its neighbour below or above, or the new
// entry, so a positional insert or remove shifts every later cell at once.
// ----------------------------------------------------------------------------
module ple_store #(
  parameter int unsigned CAPACITY = ple_pkg::CapacityDef,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  ple_pkg::store_op_e   op_i,
  input  logic [CW-1:0]        idx_i,
  input  logic signed [31:0]   value_i,
  output logic signed [31:0]   rd_data_o
);
  import ple_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);

  logic signed [31:0] ent_q [CAPACITY];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] prev_w;
      logic signed [31:0] next_w;
      logic signed [31:0] ent_d;

      // Pick the neighbour below (for insert) and above (for remove)
      if (g == 0) begin : g_first
        assign prev_w = value_i;
      end else begin : g_prev
        assign prev_w = ent_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_w = ent_q[g];
      end else begin : g_next
        assign next_w = ent_q[g+1];
      end

      // Place the new entry, shift, or hold
      always_comb begin
        ent_d = ent_q[g];
        unique case (op_i)
          OP_INSERT: begin
            if (CW'(g) == idx_i) begin
              ent_d = value_i;
            end else if (CW'(g) > idx_i) begin
              ent_d = prev_w;
            end
          end
          OP_REMOVE: begin
            if (CW'(g) >= idx_i) begin
              ent_d = next_w;
            end
          end
          default: ent_d = ent_q[g];
        endcase
      end

      always_ff @(posedge clk_i) begin
        ent_q[g] <= ent_d;
      end
    end
  endgenerate

  // Read the addressed cell before any shift
  assign rd_data_o = ent_q[idx_i[IW-1:0]];

endmodule
